// ----- design/gsu_pkg.sv -----
// shared constants for the gjk simplex update block
package gsu_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int DIR_W           = 56;
    localparam int SIMPLEX_DEPTH   = 4;
    localparam int IN_DATA_W       = 3 * FIELD_W;
    localparam int OUT_DATA_W      = 176;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    // status codes
    localparam logic [1:0] ST_CONTINUE  = 2'd0;
    localparam logic [1:0] ST_SEPARATED = 2'd1;
    localparam logic [1:0] ST_OVERLAP   = 2'd2;

    // internal widths as a function of the coordinate width
    function automatic int narrow_w(input int c);
        return c + 1;
    endfunction

    function automatic int wide_w(input int c);
        return 3 * c + 5;
    endfunction

    function automatic int acc_w(input int c);
        return 4 * c + 8;
    endfunction

endpackage

// ----- design/gsu_mac.sv -----
// shared multiply-accumulate unit: wide operand taken in two halves against a narrow one
module gsu_mac
    import gsu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   clr,
    input  logic                                   sub,
    input  logic                                   hi,
    input  logic signed [wide_w(COORD_WIDTH)-1:0]   x,
    input  logic signed [narrow_w(COORD_WIDTH)-1:0] y,
    output logic signed [acc_w(COORD_WIDTH)-1:0]    acc
);

    localparam int NW   = narrow_w(COORD_WIDTH);
    localparam int WIDE = wide_w(COORD_WIDTH);
    localparam int AW   = acc_w(COORD_WIDTH);
    localparam int H    = (WIDE + 1) / 2;
    localparam int HW   = WIDE - H;

    logic signed [H:0]        mop;
    logic signed [HW-1:0]     xh;
    logic signed [H+NW:0]     prod;
    logic signed [AW-1:0]     term;
    logic signed [AW-1:0]     acc_reg;
    logic signed [AW-1:0]     acc_next;

    always_comb
    begin
        xh   = x[WIDE-1:H];
        mop  = hi ? (H+1)'(xh) : $signed({1'b0, x[H-1:0]});
        prod = mop * y;
        term = AW'(prod);
        if (hi)
        begin
            term = term <<< H;
        end
        acc_next = (clr ? AW'(0) : acc_reg) + (sub ? -term : term);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- design/gjk_simplex_update_top.sv -----
// gjk simplex update: one support point per request, next direction and status per result
// a start request uses no multiplier; an add request runs a sequence of dot products
//   and cross products on one shared multiplier, shortest for separation and longest for
//   a tetrahedron falling back to a line
// throughput: one request at a time; a new request is taken once the previous one is finished
// reset: asynchronous, clears the simplex, the count and the direction to zero
module gjk_simplex_update_top
    import gsu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y, point_z
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // dir_x, dir_y, dir_z, status, simplex_size, zero pad
);

    localparam int NW   = narrow_w(COORD_WIDTH);
    localparam int WIDE = wide_w(COORD_WIDTH);
    localparam int AW   = acc_w(COORD_WIDTH);

    typedef logic signed [COORD_WIDTH-1:0] crd_t;
    typedef logic signed [NW-1:0]          nrw_t;
    typedef logic signed [WIDE-1:0]        wde_t;

    typedef enum logic [2:0] {W_DIR, W_AB, W_AC, W_AD, W_N, W_T} wsel_t;
    typedef enum logic [2:0] {N_PIN, N_AB, N_AC, N_AD, N_AO} nsel_t;
    typedef enum logic [1:0] {D_N, D_T, D_DIR} dest_t;

    typedef struct packed {
        logic  dot;
        wsel_t w;
        nsel_t n;
        logic  neg;
        dest_t dest;
    } job_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_MAC, S_ADD_CHK, S_OUT,
        S_LINE, S_LINE_CHK, S_LINE_T,
        S_TRI, S_TRI_1, S_TRI_2, S_TRI_3, S_TRI_4, S_TRI_AC, S_TRI_5, S_TRI_6, S_TRI_7,
        S_TET, S_TET_1, S_TET_2, S_TET_3, S_TET_4, S_TET_5, S_TET_6
    } state_t;

    function automatic job_t mk_job(input logic dot, input wsel_t w, input nsel_t n,
                                    input logic neg, input dest_t dest);
        job_t j;
        j.dot  = dot;
        j.w    = w;
        j.n    = n;
        j.neg  = neg;
        j.dest = dest;
        return j;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] v);
        case (v)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] v);
        case (v)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    state_t           state_reg, state_next, ret_reg, ret_next;
    job_t             job_reg, job_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             pos_reg, pos_next;
    logic             op_reg, op_next;
    crd_t             pin_reg [3];
    crd_t             pin_next [3];
    crd_t             pt_reg [4][3];
    crd_t             pt_next [4][3];
    nrw_t             ab_reg [3], ac_reg [3], ad_reg [3], ao_reg [3];
    nrw_t             ab_next [3], ac_next [3], ad_next [3], ao_next [3];
    wde_t             n_reg [3], t_reg [3], dir_reg [3];
    wde_t             n_next [3], t_next [3], dir_next [3];
    logic [2:0]       count_reg, count_next;
    logic [1:0]       status_reg, status_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [DIR_W-1:0] odir_reg [3];
    logic [DIR_W-1:0] odir_next [3];
    logic [1:0]       ostat_reg, ostat_next;
    logic [2:0]       osize_reg, osize_next;

    wde_t             wv [3];
    nrw_t             nv [3];
    logic [1:0]       wi, ni, di, kk, cap_k;
    logic             mac_en, mac_clr, mac_sub, mac_last;
    logic signed [AW-1:0] acc;
    logic [2:0]       cnt_inc;
    logic             call;
    job_t             call_job;
    state_t           call_ret;

    // operand selection
    always_comb
    begin
        case (job_reg.w)
            W_DIR:   wv = dir_reg;
            W_AB:    for (int i = 0; i < 3; i++) wv[i] = WIDE'(ab_reg[i]);
            W_AC:    for (int i = 0; i < 3; i++) wv[i] = WIDE'(ac_reg[i]);
            W_AD:    for (int i = 0; i < 3; i++) wv[i] = WIDE'(ad_reg[i]);
            W_N:     wv = n_reg;
            default: wv = t_reg;
        endcase
        case (job_reg.n)
            N_PIN:   for (int i = 0; i < 3; i++) nv[i] = NW'(pin_reg[i]);
            N_AB:    nv = ab_reg;
            N_AC:    nv = ac_reg;
            N_AD:    nv = ad_reg;
            default: nv = ao_reg;
        endcase
    end

    // term walk: cross is component*4 + term*2 + half, dot is element*2 + half
    always_comb
    begin
        kk    = cnt_reg[3:2];
        di    = (cnt_reg[2:1] == 2'd3) ? 2'd0 : cnt_reg[2:1];
        cap_k = cnt_reg[3:2] - 2'd1;
        if (job_reg.dot)
        begin
            wi       = di;
            ni       = di;
            mac_sub  = 1'b0;
            mac_clr  = (cnt_reg == 4'd0);
            mac_last = (cnt_reg == 4'd6);
        end
        else
        begin
            wi       = cnt_reg[1] ? dec3(kk) : inc3(kk);
            ni       = cnt_reg[1] ? inc3(kk) : dec3(kk);
            mac_sub  = cnt_reg[1] ^ job_reg.neg;
            mac_clr  = (cnt_reg[1:0] == 2'd0);
            mac_last = (cnt_reg == 4'd12);
        end
        mac_en = (state_reg == S_MAC) && !mac_last;
    end

    gsu_mac #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mac (
        .clk (clk),
        .en  (mac_en),
        .clr (mac_clr),
        .sub (mac_sub),
        .hi  (cnt_reg[0]),
        .x   (wv[wi]),
        .y   (nv[ni]),
        .acc (acc)
    );

    assign cnt_inc = (count_reg >= 3'(SIMPLEX_DEPTH)) ? 3'(SIMPLEX_DEPTH) : count_reg + 3'd1;

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        job_next      = job_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        op_next       = op_reg;
        pin_next      = pin_reg;
        pt_next       = pt_reg;
        ab_next       = ab_reg;
        ac_next       = ac_reg;
        ad_next       = ad_reg;
        ao_next       = ao_reg;
        n_next        = n_reg;
        t_next        = t_reg;
        dir_next      = dir_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        odir_next     = odir_reg;
        ostat_next    = ostat_reg;
        osize_next    = osize_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        call          = 1'b0;
        call_job      = job_reg;
        call_ret      = ret_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = s_tuser;
                    for (int i = 0; i < 3; i++)
                    begin
                        pin_next[i] = COORD_WIDTH'(s_tdata[i*FIELD_W +: FIELD_W]);
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                status_next = ST_CONTINUE;
                if (op_reg == OP_START)
                begin
                    pt_next[0] = pin_reg;
                    count_next = 3'd1;
                    for (int i = 0; i < 3; i++) dir_next[i] = -WIDE'(pin_reg[i]);
                    state_next = S_OUT;
                end
                else
                begin
                    call     = 1'b1;
                    call_job = mk_job(1'b1, W_DIR, N_PIN, 1'b0, D_T);
                    call_ret = S_ADD_CHK;
                end
            end
            S_MAC:
            begin
                if (!job_reg.dot && cnt_reg[1:0] == 2'd0 && cnt_reg != 4'd0)
                begin
                    case (job_reg.dest)
                        D_N:     n_next[cap_k]   = acc[WIDE-1:0];
                        D_T:     t_next[cap_k]   = acc[WIDE-1:0];
                        default: dir_next[cap_k] = acc[WIDE-1:0];
                    endcase
                end
                if (mac_last)
                begin
                    pos_next   = !acc[AW-1] && (acc != AW'(0));
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_ADD_CHK:
            begin
                if (!pos_reg)
                begin
                    status_next = ST_SEPARATED;
                    state_next  = S_OUT;
                end
                else
                begin
                    pt_next[3] = pt_reg[2];
                    pt_next[2] = pt_reg[1];
                    pt_next[1] = pt_reg[0];
                    pt_next[0] = pin_reg;
                    count_next = cnt_inc;
                    case (cnt_inc)
                        3'd2:    state_next = S_LINE;
                        3'd3:    state_next = S_TRI;
                        default: state_next = S_TET;
                    endcase
                end
            end
            S_LINE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ab_next[i] = NW'(pt_reg[1][i]) - NW'(pt_reg[0][i]);
                    ao_next[i] = -NW'(pt_reg[0][i]);
                end
                call     = 1'b1;
                call_job = mk_job(1'b1, W_AB, N_AO, 1'b0, D_T);
                call_ret = S_LINE_CHK;
            end
            S_LINE_CHK:
            begin
                if (pos_reg)
                begin
                    call     = 1'b1;
                    call_job = mk_job(1'b0, W_AB, N_AO, 1'b0, D_T);
                    call_ret = S_LINE_T;
                end
                else
                begin
                    count_next = 3'd1;
                    for (int i = 0; i < 3; i++) dir_next[i] = WIDE'(ao_reg[i]);
                    state_next = S_OUT;
                end
            end
            S_LINE_T:
            begin
                call     = 1'b1;
                call_job = mk_job(1'b0, W_T, N_AB, 1'b0, D_DIR);
                call_ret = S_OUT;
            end
            S_TRI:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ab_next[i] = NW'(pt_reg[1][i]) - NW'(pt_reg[0][i]);
                    ac_next[i] = NW'(pt_reg[2][i]) - NW'(pt_reg[0][i]);
                    ao_next[i] = -NW'(pt_reg[0][i]);
                end
                call     = 1'b1;
                call_job = mk_job(1'b0, W_AB, N_AC, 1'b0, D_N);
                call_ret = S_TRI_1;
            end
            S_TRI_1:
            begin
                call     = 1'b1;
                call_job = mk_job(1'b0, W_N, N_AC, 1'b0, D_T);
                call_ret = S_TRI_2;
            end
            S_TRI_2:
            begin
                call     = 1'b1;
                call_job = mk_job(1'b1, W_T, N_AO, 1'b0, D_T);
                call_ret = S_TRI_3;
            end
            S_TRI_3:
            begin
                call = 1'b1;
                if (pos_reg)
                begin
                    call_job = mk_job(1'b1, W_AC, N_AO, 1'b0, D_T);
                    call_ret = S_TRI_4;
                end
                else
                begin
                    // ab x n taken as the negated n x ab
                    call_job = mk_job(1'b0, W_N, N_AB, 1'b1, D_T);
                    call_ret = S_TRI_5;
                end
            end
            S_TRI_4:
            begin
                count_next = 3'd2;
                if (pos_reg)
                begin
                    pt_next[1] = pt_reg[2];
                    call       = 1'b1;
                    call_job   = mk_job(1'b0, W_AC, N_AO, 1'b0, D_T);
                    call_ret   = S_TRI_AC;
                end
                else
                begin
                    state_next = S_LINE;
                end
            end
            S_TRI_AC:
            begin
                call     = 1'b1;
                call_job = mk_job(1'b0, W_T, N_AC, 1'b0, D_DIR);
                call_ret = S_OUT;
            end
            S_TRI_5:
            begin
                call     = 1'b1;
                call_job = mk_job(1'b1, W_T, N_AO, 1'b0, D_T);
                call_ret = S_TRI_6;
            end
            S_TRI_6:
            begin
                if (pos_reg)
                begin
                    count_next = 3'd2;
                    state_next = S_LINE;
                end
                else
                begin
                    call     = 1'b1;
                    call_job = mk_job(1'b1, W_N, N_AO, 1'b0, D_T);
                    call_ret = S_TRI_7;
                end
            end
            S_TRI_7:
            begin
                if (pos_reg)
                begin
                    dir_next = n_reg;
                end
                else
                begin
                    // flip winding so the normal faces the origin
                    pt_next[1] = pt_reg[2];
                    pt_next[2] = pt_reg[1];
                    for (int i = 0; i < 3; i++) dir_next[i] = -n_reg[i];
                end
                state_next = S_OUT;
            end
            S_TET:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ab_next[i] = NW'(pt_reg[1][i]) - NW'(pt_reg[0][i]);
                    ac_next[i] = NW'(pt_reg[2][i]) - NW'(pt_reg[0][i]);
                    ad_next[i] = NW'(pt_reg[3][i]) - NW'(pt_reg[0][i]);
                    ao_next[i] = -NW'(pt_reg[0][i]);
                end
                call     = 1'b1;
                call_job = mk_job(1'b0, W_AB, N_AC, 1'b0, D_T);
                call_ret = S_TET_1;
            end
            S_TET_1, S_TET_3, S_TET_5:
            begin
                call     = 1'b1;
                call_job = mk_job(1'b1, W_T, N_AO, 1'b0, D_T);
                call_ret = (state_reg == S_TET_1) ? S_TET_2 :
                           (state_reg == S_TET_3) ? S_TET_4 : S_TET_6;
            end
            S_TET_2:
            begin
                if (pos_reg)
                begin
                    count_next = 3'd3;
                    state_next = S_TRI;
                end
                else
                begin
                    call     = 1'b1;
                    call_job = mk_job(1'b0, W_AC, N_AD, 1'b0, D_T);
                    call_ret = S_TET_3;
                end
            end
            S_TET_4:
            begin
                if (pos_reg)
                begin
                    pt_next[1] = pt_reg[2];
                    pt_next[2] = pt_reg[3];
                    count_next = 3'd3;
                    state_next = S_TRI;
                end
                else
                begin
                    call     = 1'b1;
                    call_job = mk_job(1'b0, W_AD, N_AB, 1'b0, D_T);
                    call_ret = S_TET_5;
                end
            end
            S_TET_6:
            begin
                if (pos_reg)
                begin
                    pt_next[1] = pt_reg[3];
                    pt_next[2] = pt_reg[1];
                    count_next = 3'd3;
                    state_next = S_TRI;
                end
                else
                begin
                    status_next = ST_OVERLAP;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    for (int i = 0; i < 3; i++) odir_next[i] = DIR_W'(dir_reg[i]);
                    ostat_next    = status_reg;
                    osize_next    = count_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (call)
        begin
            job_next   = call_job;
            ret_next   = call_ret;
            cnt_next   = 4'd0;
            state_next = S_MAC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            job_reg      <= '0;
            cnt_reg      <= '0;
            pos_reg      <= 1'b0;
            op_reg       <= 1'b0;
            pin_reg      <= '{default: '0};
            pt_reg       <= '{default: '{default: '0}};
            ab_reg       <= '{default: '0};
            ac_reg       <= '{default: '0};
            ad_reg       <= '{default: '0};
            ao_reg       <= '{default: '0};
            n_reg        <= '{default: '0};
            t_reg        <= '{default: '0};
            dir_reg      <= '{default: '0};
            count_reg    <= '0;
            status_reg   <= ST_CONTINUE;
            m_tvalid_reg <= 1'b0;
            odir_reg     <= '{default: '0};
            ostat_reg    <= '0;
            osize_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            job_reg      <= job_next;
            cnt_reg      <= cnt_next;
            pos_reg      <= pos_next;
            op_reg       <= op_next;
            pin_reg      <= pin_next;
            pt_reg       <= pt_next;
            ab_reg       <= ab_next;
            ac_reg       <= ac_next;
            ad_reg       <= ad_next;
            ao_reg       <= ao_next;
            n_reg        <= n_next;
            t_reg        <= t_next;
            dir_reg      <= dir_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
            odir_reg     <= odir_next;
            ostat_reg    <= ostat_next;
            osize_reg    <= osize_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, osize_reg, ostat_reg, odir_reg[2], odir_reg[1], odir_reg[0]};

endmodule

// ----- bench/tb.sv -----
// testbench for gjk_simplex_update_top: directed table and random gjk queries against a predictor
`timescale 1ns / 1ps

module tb
    import gsu_pkg::*;
;

    localparam int NUM_RANDOM = 1130;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec3_t;

    typedef struct {
        logic [DIR_W-1:0] dx;
        logic [DIR_W-1:0] dy;
        logic [DIR_W-1:0] dz;
        logic [1:0]       status;
        logic [2:0]       size;
    } step_result_t;

    typedef struct {
        logic        op;
        int          x;
        int          y;
        int          z;
        bit          typed;
        longint      dx;
        longint      dy;
        longint      dz;
        logic [1:0]  status;
        logic [2:0]  size;
    } table_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // point_x, point_y, point_z
    logic                  s_tuser;   // operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // dir_x, dir_y, dir_z, status, simplex_size, zero pad

    gjk_simplex_update_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state
    vec3_t  pts [SIMPLEX_DEPTH];
    int     pt_count;
    vec3_t  search_dir;

    step_result_t expected_steps [$];
    int errors;
    int phase;          // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    bit hold_request;
    int n_sent;
    int n_status [3];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #30ms;
        $display("tb failed");
        $finish;
    end

    function automatic vec3_t vsub(vec3_t a, vec3_t b);
        vec3_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic vec3_t vneg(vec3_t a);
        vec3_t r;
        r.x = -a.x;
        r.y = -a.y;
        r.z = -a.z;
        return r;
    endfunction

    function automatic vec3_t vcross(vec3_t a, vec3_t b);
        vec3_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    // exact dot product sign, strictly positive only
    function automatic bit dot_positive(vec3_t a, vec3_t b);
        logic signed [127:0] ax, ay, az, bx, by, bz, acc;
        ax = a.x; ay = a.y; az = a.z;
        bx = b.x; by = b.y; bz = b.z;
        acc = ax * bx + ay * by + az * bz;
        return acc > 0;
    endfunction

    function automatic void reduce_line();
        vec3_t a, ab, ao;
        a = pts[0];
        ab = vsub(pts[1], a);
        ao = vneg(a);
        if (dot_positive(ab, ao))
            search_dir = vcross(vcross(ab, ao), ab);
        else
        begin
            pt_count = 1;
            search_dir = ao;
        end
    endfunction

    function automatic void reduce_triangle();
        vec3_t a, b, c, ab, ac, ao, n;
        a = pts[0];
        b = pts[1];
        c = pts[2];
        ab = vsub(b, a);
        ac = vsub(c, a);
        ao = vneg(a);
        n = vcross(ab, ac);
        if (dot_positive(vcross(n, ac), ao))
        begin
            if (dot_positive(ac, ao))
            begin
                pts[1] = c;
                pt_count = 2;
                search_dir = vcross(vcross(ac, ao), ac);
            end
            else
            begin
                pt_count = 2;
                reduce_line();
            end
        end
        else if (dot_positive(vcross(ab, n), ao))
        begin
            pt_count = 2;
            reduce_line();
        end
        else if (dot_positive(n, ao))
            search_dir = n;
        else
        begin
            pts[1] = c;
            pts[2] = b;
            search_dir = vneg(n);
        end
    endfunction

    // returns 1 when the tetrahedron encloses the origin
    function automatic bit reduce_tetra();
        vec3_t a, b, c, d, ab, ac, ad, ao;
        a = pts[0];
        b = pts[1];
        c = pts[2];
        d = pts[3];
        ab = vsub(b, a);
        ac = vsub(c, a);
        ad = vsub(d, a);
        ao = vneg(a);
        if (dot_positive(vcross(ab, ac), ao))
        begin
            pt_count = 3;
            reduce_triangle();
            return 1'b0;
        end
        if (dot_positive(vcross(ac, ad), ao))
        begin
            pts[1] = c;
            pts[2] = d;
            pt_count = 3;
            reduce_triangle();
            return 1'b0;
        end
        if (dot_positive(vcross(ad, ab), ao))
        begin
            pts[2] = b;
            pts[1] = d;
            pt_count = 3;
            reduce_triangle();
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic step_result_t gjk_step(logic op, logic [IN_DATA_W-1:0] raw);
        step_result_t r;
        vec3_t p;
        logic [1:0] st;
        st = ST_CONTINUE;
        p.x = longint'($signed(raw[15:0]));
        p.y = longint'($signed(raw[31:16]));
        p.z = longint'($signed(raw[47:32]));
        if (op == OP_START)
        begin
            pts[0] = p;
            pt_count = 1;
            search_dir = vneg(p);
        end
        else if (!dot_positive(p, search_dir))
            st = ST_SEPARATED;
        else
        begin
            for (int i = SIMPLEX_DEPTH - 1; i > 0; i--)
                pts[i] = pts[i-1];
            pts[0] = p;
            if (pt_count < SIMPLEX_DEPTH)
                pt_count++;
            if (pt_count == 2)
                reduce_line();
            else if (pt_count == 3)
                reduce_triangle();
            else if (pt_count == 4 && reduce_tetra())
                st = ST_OVERLAP;
        end
        r.dx = search_dir.x[DIR_W-1:0];
        r.dy = search_dir.y[DIR_W-1:0];
        r.dz = search_dir.z[DIR_W-1:0];
        r.status = st;
        r.size = pt_count[2:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // drives one request and returns once it has been taken
    task automatic send_request(input logic op, input int x, input int y, input int z,
                                output step_result_t pred);
        logic [IN_DATA_W-1:0] raw;
        int gap_pct;
        raw = {z[15:0], y[15:0], x[15:0]};
        gap_pct = (phase == 1) ? 53 : (phase == 3) ? 35 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= raw;
        do @(posedge clk); while (!s_tready);
        pred = gjk_step(op, raw);
        expected_steps.insert(expected_steps.size(), pred);
        n_sent++;
    endtask

    // coordinate biased toward the sign of a direction component
    function automatic int toward(longint d, int mag);
        int v;
        v = $urandom_range(0, mag);
        if (d < 0 || (d == 0 && $urandom_range(1) == 1))
            v = -v;
        return v;
    endfunction

    // receiver: random stalls per phase, plus a long counted hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        int hold_left;
        int stall_pct;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            stall_pct = (phase == 2) ? 53 : (phase == 3) ? 35 : 0;
            if (hold_request && hold_left == 0)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        step_result_t got, exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.dx = m_tdata[55:0];
            got.dy = m_tdata[111:56];
            got.dz = m_tdata[167:112];
            got.status = m_tdata[169:168];
            got.size = m_tdata[172:170];
            if (expected_steps.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_r = expected_steps.pop_front();
                if (got.status <= ST_OVERLAP)
                    n_status[got.status]++;
                if (got.dx !== exp_r.dx)
                    report_mismatch($sformatf("dir_x %h exp %h", got.dx, exp_r.dx));
                if (got.dy !== exp_r.dy)
                    report_mismatch($sformatf("dir_y %h exp %h", got.dy, exp_r.dy));
                if (got.dz !== exp_r.dz)
                    report_mismatch($sformatf("dir_z %h exp %h", got.dz, exp_r.dz));
                if (got.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d exp %0d", got.status, exp_r.status));
                if (got.size !== exp_r.size)
                    report_mismatch($sformatf("simplex_size %0d exp %0d",
                                              got.size, exp_r.size));
            end
        end
    end

    initial
    begin
        table_row_t rows [$];
        step_result_t pred;
        int adds;
        int mag;
        int x, y, z;
        int waited;
        bit held;

        errors = 0;
        phase = 0;
        hold_request = 1'b0;
        held = 1'b0;
        n_sent = 0;
        n_status = '{0, 0, 0};
        pts = '{default: '{0, 0, 0}};
        pt_count = 0;
        search_dir = '{0, 0, 0};
        s_tvalid = 1'b0;
        s_tuser = OP_START;
        s_tdata = '0;
        rst_n = 1'b0;

        // add before any start: zero direction, tie means separated
        rows.insert(rows.size(), '{OP_ADD, 100, 0, 0, 1, 0, 0, 0, ST_SEPARATED, 3'd0});
        rows.insert(rows.size(), '{OP_START, -32768, -32768, -32768, 1, 32768, 32768, 32768,
                                   ST_CONTINUE, 3'd1});
        rows.insert(rows.size(), '{OP_ADD, 32767, 32767, 32767, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, -32768, 32767, 0, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, 0, -32768, 32767, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, 1, 1, -32768, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_START, 32767, 0, -1, 1, -32767, 0, 1, ST_CONTINUE, 3'd1});
        // zero dot product counts as separated
        rows.insert(rows.size(), '{OP_ADD, 0, 0, 0, 1, -32767, 0, 1, ST_SEPARATED, 3'd1});
        rows.insert(rows.size(), '{OP_START, 0, 0, 0, 1, 0, 0, 0, ST_CONTINUE, 3'd1});
        rows.insert(rows.size(), '{OP_ADD, 5, 5, 5, 1, 0, 0, 0, ST_SEPARATED, 3'd1});
        // a small tetrahedron around the origin
        rows.insert(rows.size(), '{OP_START, 256, 10, 20, 1, -256, -10, -20, ST_CONTINUE, 3'd1});
        rows.insert(rows.size(), '{OP_ADD, -256, 30, 0, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, 0, 300, -200, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, 0, -300, -200, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, 10, 0, 400, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, 0, 0, 500, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_ADD, 1000, -2000, 3000, 0, 0, 0, 0, ST_CONTINUE, 3'd0});
        rows.insert(rows.size(), '{OP_START, 32767, 32767, 32767, 1, -32767, -32767, -32767,
                                   ST_CONTINUE, 3'd1});
        rows.insert(rows.size(), '{OP_ADD, -32768, -32768, -32768, 0, 0, 0, 0,
                                   ST_CONTINUE, 3'd0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_request(rows[i].op, rows[i].x, rows[i].y, rows[i].z, pred);
            if (rows[i].typed && (pred.dx !== rows[i].dx[DIR_W-1:0]
                    || pred.dy !== rows[i].dy[DIR_W-1:0] || pred.dz !== rows[i].dz[DIR_W-1:0]
                    || pred.status !== rows[i].status || pred.size !== rows[i].size))
                report_mismatch($sformatf("table row %0d disagrees with predictor", i));
            // typed rows override the predictor so the dut is held to the table
            if (rows[i].typed)
                expected_steps[$] = '{rows[i].dx[DIR_W-1:0], rows[i].dy[DIR_W-1:0],
                                      rows[i].dz[DIR_W-1:0], rows[i].status, rows[i].size};
        end

        // random queries: a start, then adds mostly along the search direction; sometimes a lone random add
        while (n_sent < NUM_RANDOM + rows.size())
        begin
            phase = ((n_sent - rows.size()) * 4 / NUM_RANDOM) % 4;
            if (!held && n_sent >= rows.size() + 100)
            begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            mag = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(4, 12));
            if ($urandom_range(9) == 0)
                send_request(OP_ADD, $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), pred);
            else
            begin
                send_request(OP_START, $urandom_range(0, 2 * mag) - mag,
                             $urandom_range(0, 2 * mag) - mag,
                             $urandom_range(0, 2 * mag) - mag, pred);
                adds = $urandom_range(1, 7);
                for (int k = 0; k < adds; k++)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        x = $urandom_range(0, 65535);
                        y = $urandom_range(0, 65535);
                        z = $urandom_range(0, 65535);
                    end
                    else
                    begin
                        x = toward(search_dir.x, mag);
                        y = toward(search_dir.y, mag);
                        z = toward(search_dir.z, mag);
                    end
                    send_request(OP_ADD, x, y, z, pred);
                end
            end
        end
        s_tvalid <= 1'b0;
        phase = 0;

        waited = 0;
        while (expected_steps.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (expected_steps.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_steps.size()));

        $display("covered %0d requests in four idle phases with a long receiver hold-off",
                 n_sent);
        $display("results: %0d continue, %0d separated, %0d overlap",
                 n_status[0], n_status[1], n_status[2]);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
